// File: rtl/core/lru_cache_with_expiry_assert.svh
// ----------------------------------------------------------------------------
// lru_cache_with_expiry assertion macros
// Concurrent assertion wrappers; they are empty in synthesis builds.
// ----------------------------------------------------------------------------
`ifndef LRU_CACHE_WITH_EXPIRY_ASSERT_SVH
`define LRU_CACHE_WITH_EXPIRY_ASSERT_SVH
`ifndef SYNTHESIS
// Same-cycle implication.
`define LCE_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("lce assertion failed");
// Next-cycle implication.
`define LCE_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("lce assertion failed");
`else
`define LCE_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define LCE_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif
`endif

// File: rtl/core/lce_pkg.sv
// ----------------------------------------------------------------------------
// lce_pkg
// Shared constants, codes and types of the LRU cache with expiry.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
package lce_pkg;
    localparam int SLOTS_DEF      = 64;
    localparam int KEY_BITS_DEF   = 32;
    localparam int VALUE_BITS_DEF = 32;
    localparam int TIME_W         = 32;
    localparam int TIMEOUT_W      = 24;
    localparam int MAXE_W         = 7;
    localparam int CNT_OUT_W      = 7;
    localparam int FUNC_W         = 2;
    localparam int CFG_W          = 24;

    localparam logic [MAXE_W-1:0]    MAXE_RESET    = 7'd64;
    localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET = 24'd60;

    // Request codes.
    localparam logic [FUNC_W-1:0] FUNC_LOOKUP = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_ENTER  = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_REMOVE = 2'd2;
    localparam logic [FUNC_W-1:0] FUNC_FLUSH  = 2'd3;

    // Register indexes.
    localparam logic CFG_MAX_ENTRIES = 1'b0;
    localparam logic CFG_TIMEOUT     = 1'b1;

    // Cell operations.
    localparam logic [1:0] OP_NONE  = 2'd0;
    localparam logic [1:0] OP_TOUCH = 2'd1;
    localparam logic [1:0] OP_DROP  = 2'd2;
    localparam logic [1:0] OP_FILL  = 2'd3;

    typedef struct packed {
        logic [1:0] op;
        logic       evict;
        logic       wr;
    } t_cell_cmd;
endpackage

// File: rtl/core/lce_cell.sv
// ----------------------------------------------------------------------------
// lce_cell
// One cache slot: key, value, expiry, valid bit and recency rank.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module lce_cell import lce_pkg::*; #(
    parameter int KEY_W  = KEY_BITS_DEF,
    parameter int VAL_W  = VALUE_BITS_DEF,
    parameter int RANK_W = 6
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_cell_cmd         i_cmd,
    input  logic [RANK_W-1:0] i_rank,
    input  logic [KEY_W-1:0]  i_key,
    input  logic [VAL_W-1:0]  i_value,
    input  logic [TIME_W-1:0] i_expiry,
    input  logic [TIME_W-1:0] i_now,
    input  logic              i_free_prior,
    output logic              o_free_prior,
    input  logic              i_exp_prior,
    output logic              o_exp_prior,
    output logic              o_match,
    output logic              o_expired,
    output logic              o_exp_take,
    output logic [RANK_W-1:0] o_rank,
    output logic [VAL_W-1:0]  o_value
);
    logic              r_valid;
    logic [RANK_W-1:0] r_rank;
    logic [KEY_W-1:0]  r_key;
    logic [VAL_W-1:0]  r_value;
    logic [TIME_W-1:0] r_expiry;
    logic              w_sel;
    logic              w_free_take;
    logic              w_exp_cand;
    logic              w_target;

    // Match, expiry and the two priority chains toward the neighbor.
    assign o_match      = r_valid && (r_key == i_key);
    assign o_expired    = r_expiry <= i_now;
    assign w_exp_cand   = r_valid && o_expired;
    assign o_exp_take   = w_exp_cand && !i_exp_prior;
    assign o_exp_prior  = i_exp_prior || w_exp_cand;
    assign w_free_take  = !r_valid && !i_free_prior;
    assign o_free_prior = i_free_prior || !r_valid;
    assign w_sel        = r_valid && (r_rank == i_rank);
    assign w_target     = i_cmd.evict ? w_sel : w_free_take;
    assign o_rank       = r_rank;
    assign o_value      = r_value;

    // Valid bit and rank follow the broadcast operation.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_rank  <= '0;
        end else begin
            case (i_cmd.op)
                OP_TOUCH: begin
                    if (w_sel) begin
                        r_rank <= '0;
                    end else if (r_valid && r_rank < i_rank) begin
                        r_rank <= r_rank + 1'b1;
                    end
                end
                OP_DROP: begin
                    if (w_sel) begin
                        r_valid <= 1'b0;
                    end else if (r_valid && r_rank > i_rank) begin
                        r_rank <= r_rank - 1'b1;
                    end
                end
                OP_FILL: begin
                    if (w_target) begin
                        r_valid <= 1'b1;
                        r_rank  <= '0;
                    end else if (r_valid) begin
                        r_rank <= r_rank + 1'b1;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // Payload of the slot.
    always_ff @(posedge i_clk) begin
        if (i_cmd.op == OP_FILL && w_target) begin
            r_key    <= i_key;
            r_value  <= i_value;
            r_expiry <= i_expiry;
        end else if (i_cmd.op == OP_TOUCH && i_cmd.wr && w_sel) begin
            r_value  <= i_value;
            r_expiry <= i_expiry;
        end
    end
endmodule

// File: rtl/core/lru_cache_with_expiry.sv
// Steps: the request is registered in idle; act matches it and touches or drops the
// slot; new fills a slot; flush drops expired entries; out fills the output register.
// Throughput: one item at a time; the next item can be taken once
// the result has moved into the output register.
// Reset (synchronous, active low) clears all valid bits and the count.
// ----------------------------------------------------------------------------
// lru_cache_with_expiry
// Fully associative key/value cache with LRU order and per-entry expiry.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "lru_cache_with_expiry_assert.svh"
module lru_cache_with_expiry import lce_pkg::*; #(
    parameter int SLOTS      = SLOTS_DEF,
    parameter int KEY_BITS   = KEY_BITS_DEF,
    parameter int VALUE_BITS = VALUE_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic                  i_cfg_idx,
    input  logic [CFG_W-1:0]      i_cfg_wdata,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  logic [FUNC_W-1:0]     i_func,
    input  logic [KEY_BITS-1:0]   i_key,
    input  logic [VALUE_BITS-1:0] i_value_in,
    input  logic [TIME_W-1:0]     i_now_time,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output logic                  o_hit,
    output logic [VALUE_BITS-1:0] o_value_out,
    output logic                  o_recycled,
    output logic [CNT_OUT_W-1:0]  o_dropped_count,
    output logic [CNT_OUT_W-1:0]  o_live_entries
);
    localparam int RANK_W = $clog2(SLOTS);
    localparam int CNT_W  = $clog2(SLOTS + 1);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_ACT   = 3'd1;
    localparam logic [2:0] S_NEW   = 3'd2;
    localparam logic [2:0] S_FLUSH = 3'd3;
    localparam logic [2:0] S_OUT   = 3'd4;

    logic [2:0]            r_state;
    logic [2:0]            n_state;
    logic [FUNC_W-1:0]     r_func;
    logic [KEY_BITS-1:0]   r_key;
    logic [VALUE_BITS-1:0] r_val;
    logic [TIME_W-1:0]     r_now;
    logic [CNT_W-1:0]      r_count;
    logic [MAXE_W-1:0]     r_max;
    logic [TIMEOUT_W-1:0]  r_timeout;
    logic                  r_hit;
    logic [VALUE_BITS-1:0] r_vout;
    logic                  r_recycled;
    logic [CNT_W-1:0]      r_dropped;
    logic                  r_ovalid;
    logic                  r_o_hit;
    logic [VALUE_BITS-1:0] r_o_vout;
    logic                  r_o_recycled;
    logic [CNT_W-1:0]      r_o_dropped;
    logic [CNT_W-1:0]      r_o_live;

    t_cell_cmd             w_cmd;
    logic [RANK_W-1:0]     w_rank;
    logic [CNT_W-1:0]      w_lim;
    logic [TIME_W:0]       w_sum;
    logic [TIME_W-1:0]     w_exp;
    logic                  w_full;
    logic                  w_out_free;

    logic [SLOTS:0]        w_free_chain;
    logic [SLOTS:0]        w_exp_chain;
    logic [SLOTS-1:0]      w_match;
    logic [SLOTS-1:0]      w_expired;
    logic [SLOTS-1:0]      w_take;
    logic [RANK_W-1:0]     w_cell_rank [SLOTS];
    logic [VALUE_BITS-1:0] w_cell_value [SLOTS];

    logic                  w_any_match;
    logic                  w_m_exp;
    logic [RANK_W-1:0]     w_m_rank;
    logic [VALUE_BITS-1:0] w_m_value;
    logic                  w_fl_found;
    logic [RANK_W-1:0]     w_fl_rank;

    // Effective limit, clamped to one .. SLOTS.
    always_comb begin
        if (r_max == '0) begin
            w_lim = CNT_W'(1);
        end else if (int'(r_max) > SLOTS) begin
            w_lim = CNT_W'(SLOTS);
        end else begin
            w_lim = CNT_W'(int'(r_max));
        end
    end

    // Expiry stamp, saturated at the largest time.
    assign w_sum  = {1'b0, r_now} + {{(TIME_W + 1 - TIMEOUT_W){1'b0}}, r_timeout};
    assign w_exp  = w_sum[TIME_W] ? {TIME_W{1'b1}} : w_sum[TIME_W-1:0];
    assign w_full = !(r_count < w_lim);

    // Row of slot cells.
    assign w_free_chain[0] = 1'b0;
    assign w_exp_chain[0]  = 1'b0;
    for (genvar g = 0; g < SLOTS; g++) begin : g_cell
        lce_cell #(
            .KEY_W  (KEY_BITS),
            .VAL_W  (VALUE_BITS),
            .RANK_W (RANK_W)
        ) u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_cmd        (w_cmd),
            .i_rank       (w_rank),
            .i_key        (r_key),
            .i_value      (r_val),
            .i_expiry     (w_exp),
            .i_now        (r_now),
            .i_free_prior (w_free_chain[g]),
            .o_free_prior (w_free_chain[g+1]),
            .i_exp_prior  (w_exp_chain[g]),
            .o_exp_prior  (w_exp_chain[g+1]),
            .o_match      (w_match[g]),
            .o_expired    (w_expired[g]),
            .o_exp_take   (w_take[g]),
            .o_rank       (w_cell_rank[g]),
            .o_value      (w_cell_value[g])
        );
    end

    // Gather the matching slot and the first expired slot.
    always_comb begin
        w_any_match = 1'b0;
        w_m_exp     = 1'b0;
        w_m_rank    = '0;
        w_m_value   = '0;
        w_fl_found  = 1'b0;
        w_fl_rank   = '0;
        for (int i = 0; i < SLOTS; i++) begin
            w_any_match = w_any_match | w_match[i];
            w_m_exp     = w_m_exp | (w_match[i] & w_expired[i]);
            w_m_rank    = w_m_rank | (w_match[i] ? w_cell_rank[i] : '0);
            w_m_value   = w_m_value | (w_match[i] ? w_cell_value[i] : '0);
            w_fl_found  = w_fl_found | w_take[i];
            w_fl_rank   = w_fl_rank | (w_take[i] ? w_cell_rank[i] : '0);
        end
    end

    // Operation broadcast to the cells.
    always_comb begin
        w_cmd  = '{op: OP_NONE, evict: 1'b0, wr: 1'b0};
        w_rank = w_m_rank;
        case (r_state)
            S_ACT: begin
                if (r_func != FUNC_FLUSH && w_any_match) begin
                    if (w_m_exp || r_func == FUNC_REMOVE) begin
                        w_cmd.op = OP_DROP;
                    end else begin
                        w_cmd.op = OP_TOUCH;
                        w_cmd.wr = (r_func == FUNC_ENTER);
                    end
                end
            end
            S_NEW: begin
                w_cmd.op    = OP_FILL;
                w_cmd.evict = w_full;
                w_rank      = RANK_W'(r_count - 1'b1);
            end
            S_FLUSH: begin
                if (w_fl_found) begin
                    w_cmd.op = OP_DROP;
                end
                w_rank = w_fl_rank;
            end
            default: begin
            end
        endcase
    end

    assign w_out_free = !r_ovalid || i_out_ready;

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = S_ACT;
                end
            end
            S_ACT: begin
                if (r_func == FUNC_FLUSH) begin
                    n_state = S_FLUSH;
                end else if (r_func == FUNC_ENTER && (!w_any_match || w_m_exp)) begin
                    n_state = S_NEW;
                end else begin
                    n_state = S_OUT;
                end
            end
            S_NEW: begin
                n_state = S_OUT;
            end
            S_FLUSH: begin
                if (!w_fl_found) begin
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                if (w_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control state, count and registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_count   <= '0;
            r_ovalid  <= 1'b0;
            r_max     <= MAXE_RESET;
            r_timeout <= TIMEOUT_RESET;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                if (i_cfg_idx == CFG_MAX_ENTRIES) begin
                    r_max <= i_cfg_wdata[MAXE_W-1:0];
                end else begin
                    r_timeout <= i_cfg_wdata[TIMEOUT_W-1:0];
                end
            end
            if (r_state == S_ACT && r_func != FUNC_FLUSH && w_any_match
                    && (w_m_exp || r_func == FUNC_REMOVE)) begin
                r_count <= r_count - 1'b1;
            end else if (r_state == S_NEW && !w_full) begin
                r_count <= r_count + 1'b1;
            end else if (r_state == S_FLUSH && w_fl_found) begin
                r_count <= r_count - 1'b1;
            end
            if (r_state == S_OUT && w_out_free) begin
                r_ovalid <= 1'b1;
            end else if (i_out_ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    // Request and result payload.
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    r_func     <= i_func;
                    r_key      <= i_key;
                    r_val      <= i_value_in;
                    r_now      <= i_now_time;
                    r_hit      <= 1'b0;
                    r_vout     <= '0;
                    r_recycled <= 1'b0;
                    r_dropped  <= '0;
                end
            end
            S_ACT: begin
                if (r_func != FUNC_FLUSH && w_any_match) begin
                    if (w_m_exp) begin
                        r_dropped <= CNT_W'(1);
                    end else begin
                        r_hit  <= 1'b1;
                        r_vout <= w_m_value;
                        if (r_func == FUNC_REMOVE) begin
                            r_dropped <= CNT_W'(1);
                        end
                    end
                end
            end
            S_NEW: begin
                r_recycled <= w_full;
            end
            S_FLUSH: begin
                if (w_fl_found) begin
                    r_dropped <= r_dropped + 1'b1;
                end
            end
            S_OUT: begin
                if (w_out_free) begin
                    r_o_hit      <= r_hit;
                    r_o_vout     <= r_vout;
                    r_o_recycled <= r_recycled;
                    r_o_dropped  <= r_dropped;
                    r_o_live     <= r_count;
                end
            end
            default: begin
            end
        endcase
    end

    assign o_in_ready      = (r_state == S_IDLE);
    assign o_out_valid     = r_ovalid;
    assign o_hit           = r_o_hit;
    assign o_value_out     = r_o_vout;
    assign o_recycled      = r_o_recycled;
    assign o_dropped_count = CNT_OUT_W'(r_o_dropped);
    assign o_live_entries  = CNT_OUT_W'(r_o_live);

    // Checks on the control flow.
    `LCE_ASSERT_IMP(a_count_bound, i_clk, i_rst_n, 1'b1, int'(r_count) <= SLOTS)
    `LCE_ASSERT_NXT(a_accept_to_act, i_clk, i_rst_n, i_in_valid && o_in_ready, r_state == S_ACT)
    `LCE_ASSERT_NXT(a_flush_done, i_clk, i_rst_n, r_state == S_FLUSH && !w_fl_found, r_state == S_OUT)
    `LCE_ASSERT_NXT(a_evict_keeps, i_clk, i_rst_n, r_state == S_NEW && w_full, $stable(r_count))
endmodule
